FILE: rtl/core/rbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rbd_pkg;

    localparam int unsigned RingLen   = 100;
    localparam int unsigned ConfTaps  = 10;
    localparam int unsigned RateScale = 30;

    localparam int unsigned SampleW = 10;
    localparam int unsigned PctW    = 7;
    localparam int unsigned LenW    = 5;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDatW = 10;
    localparam int unsigned SerW    = 18;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_DIP     = 2'd1,
        PH_RECOVER = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        CFG_SEED    = 3'd0,
        CFG_THRESH  = 3'd1,
        CFG_END     = 3'd2,
        CFG_RECOVER = 3'd3,
        CFG_MIN_LEN = 3'd4,
        CFG_MAX_LEN = 3'd5,
        CFG_MAX_PCT = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_JUDGE,
        ST_SUM,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                start;
        logic [SerW-1:0]     dividend;
        logic [SerW-1:0]     divisor;
    } t_div_req;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [SerW-1:0]     quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

FILE: rtl/core/rbd_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rbd_in_if;
    logic                             valid;
    logic                             ready;
    logic [rbd_pkg::SampleW-1:0]      sample;
    logic                             window_end;
    modport source (output valid, sample, window_end, input ready);
    modport sink   (input valid, sample, window_end, output ready);
endinterface

interface rbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] amplitude;
    logic       blink_counted;
    logic [1:0] detector_state;
    logic [7:0] blink_rate;
    logic [6:0] confidence;
    logic [1:0] quality;
    logic       rate_updated;
    modport source (output valid, amplitude, blink_counted, detector_state, blink_rate,
                    confidence, quality, rate_updated, input ready);
    modport sink   (input valid, amplitude, blink_counted, detector_state, blink_rate,
                    confidence, quality, rate_updated, output ready);
endinterface

interface rbd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rbd_pkg::CfgIdxW-1:0]      index;
    logic [rbd_pkg::CfgDatW-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rbd_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rbd_div (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  rbd_pkg::t_div_req      i_req,
    output rbd_pkg::t_div_rsp      o_rsp
);
    localparam int unsigned W  = rbd_pkg::SerW;
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  r_quo, n_quo;
    logic [W:0]    r_rem, n_rem;
    logic [W-1:0]  r_dvs, n_dvs;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [W:0]    w_trial;

    always_comb begin
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        w_trial = {r_rem[W-1:0], r_quo[W-1]};
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
            n_cnt  = CW'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_dvs}) begin
                n_rem = w_trial - {1'b0, r_dvs};
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without busy");
    a_no_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_done && r_busy && !$past(i_req.start))) else $error("divider busy and done");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0)) else $error("divider count lost");
`endif
endmodule
`default_nettype wire

FILE: rtl/core/rbd_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module rbd_mul (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire [rbd_pkg::SerW-1:0]    i_a,
    input  wire [rbd_pkg::PctW-1:0]    i_b,
    output logic                       o_done,
    output logic [rbd_pkg::SerW-1:0]   o_prod
);
    localparam int unsigned W  = rbd_pkg::SerW;
    localparam int unsigned B  = rbd_pkg::PctW;
    localparam int unsigned CW = $clog2(B + 1);

    logic [W-1:0]  r_acc, n_acc;
    logic [W-1:0]  r_a, n_a;
    logic [B-1:0]  r_b, n_b;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_done, n_done;

    always_comb begin
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_acc = '0;
            n_a   = i_a;
            n_b   = i_b;
            n_cnt = CW'(B);
        end else if (r_cnt != '0) begin
            if (r_b[0]) n_acc = r_acc + r_a;
            n_a   = {r_a[W-2:0], 1'b0};
            n_b   = r_b >> 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule
`default_nettype wire

FILE: rtl/core/reflectance_blink_detector.sv
// Reflectance blink detector.
// Channels: in (sample, window_end), out (one result word per input word),
// cfg (register index and data, always ready; to be written only while
// idle, which the block itself does not enforce). Each input word runs
// through a sequencer that reuses a bit-serial multiplier and a restoring
// divider for the baseline, the thresholds and the dip depth; at a window
// end a ten-tap deviation sum takes one tap a cycle.
// Each result passes through the serial divider (up to two divides) and
// the multiplier (up to three products), plus the tap sum at a window end
// once the ring has filled. One word is in flight at a time; in.ready is
// high only in idle with no result pending, so a new word is taken only
// after the last result has been taken.
// Reset (synchronous, active low) restores the register defaults, clears the
// baseline, phase, tally, held rate and confidence, ring position and taps.
// When the receiver stalls the result stays in the output register and the
// block takes no new word until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module reflectance_blink_detector #(
    parameter int unsigned RING_LEN   = rbd_pkg::RingLen,
    parameter int unsigned CONF_TAPS  = rbd_pkg::ConfTaps,
    parameter int unsigned RATE_SCALE = rbd_pkg::RateScale
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    rbd_in_if.sink    in,
    rbd_out_if.source out,
    rbd_cfg_if.sink   cfg
);
    localparam int unsigned SW = rbd_pkg::SampleW;
    localparam int unsigned W  = rbd_pkg::SerW;
    localparam int unsigned TW = (CONF_TAPS > 1) ? $clog2(CONF_TAPS) : 1;
    localparam int unsigned TCW = $clog2(CONF_TAPS + 1);
    localparam int unsigned SUMW = SW + $clog2(CONF_TAPS + 1);

    typedef enum logic [3:0] {
        K_BASE_MUL, K_BASE_DIV, K_THR_MUL, K_THR_DIV,
        K_END_MUL, K_REC_MUL, K_DEPTH_MUL, K_DEPTH_DIV, K_DONE
    } t_step;

    logic [SW-1:0] r_seed;
    logic [6:0]    r_thr, r_endp, r_recp, r_maxp;
    logic [4:0]    r_minl, r_maxl;

    rbd_pkg::t_state r_st, n_st;
    t_step           r_k, n_k;

    logic [SW-1:0] r_v;
    logic          r_wend;
    logic [SW-1:0] r_base, r_pre, r_dmin;
    logic          r_seeded;
    rbd_pkg::t_phase r_ph;
    logic [4:0]    r_dlen;
    logic [7:0]    r_tally, r_rate;
    logic [6:0]    r_conf;
    logic [6:0]    r_rpos;
    logic          r_filled;
    logic [SW-1:0] r_taps [CONF_TAPS];
    logic [SW-1:0] r_thres;
    logic [W-1:0]  r_cmp;
    logic          r_counted, r_upd;
    logic [TCW-1:0] r_ti;
    logic [SUMW-1:0] r_sum;
    logic          r_ovalid;

    logic          w_mstart, w_mdone;
    logic [W-1:0]  w_ma, w_mprod;
    logic [6:0]    w_mb;
    rbd_pkg::t_div_req w_dreq;
    rbd_pkg::t_div_rsp w_drsp;

    rbd_mul u_mul (.i_clk, .i_rst_n, .i_start(w_mstart), .i_a(w_ma), .i_b(w_mb),
                   .o_done(w_mdone), .o_prod(w_mprod));
    rbd_div u_div (.i_clk, .i_rst_n, .i_req(w_dreq), .o_rsp(w_drsp));

    assign cfg.ready = 1'b1;
    assign in.ready  = (r_st == rbd_pkg::ST_IDLE) && !r_ovalid;

    logic        w_acc;
    logic [6:0]  w_p;
    logic [W-1:0] w_v100;
    logic        w_len_ok, w_pct_ok;
    logic [SW-1:0] w_tap, w_dev;
    logic [7:0]  w_rmul;

    assign w_acc  = in.valid && in.ready;
    assign w_p    = (r_thr > 7'd100) ? 7'd100 : r_thr;
    assign w_v100 = W'(r_v) * W'(100);
    assign w_len_ok = (r_dlen >= r_minl) && (r_dlen <= r_maxl);
    assign w_pct_ok = (w_drsp.quotient >= W'(r_thr)) && (w_drsp.quotient <= W'(r_maxp));
    assign w_tap = r_taps[r_ti[TW-1:0]];
    assign w_dev = (w_tap > r_base) ? w_tap - r_base : r_base - w_tap;
    assign w_rmul = ((r_tally * RATE_SCALE) > 255) ? 8'd255 : 8'(r_tally * RATE_SCALE);

    // Sequencer: kick serial units and fold their results in.
    always_comb begin
        w_mstart = 1'b0;
        w_ma     = '0;
        w_mb     = '0;
        w_dreq   = '0;
        n_st     = r_st;
        n_k      = r_k;
        unique case (r_st)
            rbd_pkg::ST_IDLE: if (w_acc) begin
                n_st = rbd_pkg::ST_MUL;
                n_k  = K_BASE_MUL;
                w_mstart = 1'b1;
                w_ma = W'(r_seeded ? r_base : r_seed);
                w_mb = 7'd19;
            end
            rbd_pkg::ST_MUL: if (w_mdone) begin
                case (r_k)
                    K_BASE_MUL: begin
                        w_dreq.start = 1'b1;
                        w_dreq.dividend = w_mprod + W'(r_v);
                        w_dreq.divisor = W'(20);
                        n_st = rbd_pkg::ST_DIV;
                        n_k = K_BASE_DIV;
                    end
                    K_THR_MUL: begin
                        w_dreq.start = 1'b1;
                        w_dreq.dividend = w_mprod;
                        w_dreq.divisor = W'(100);
                        n_st = rbd_pkg::ST_DIV;
                        n_k = K_THR_DIV;
                    end
                    K_DEPTH_MUL: begin
                        w_dreq.start = 1'b1;
                        w_dreq.dividend = w_mprod;
                        w_dreq.divisor = W'(r_pre);
                        n_st = rbd_pkg::ST_DIV;
                        n_k = K_DEPTH_DIV;
                    end
                    default: n_st = rbd_pkg::ST_JUDGE;
                endcase
            end
            rbd_pkg::ST_DIV: if (w_drsp.done) begin
                case (r_k)
                    K_BASE_DIV: begin
                        w_mstart = 1'b1;
                        w_ma = w_drsp.quotient;
                        n_st = rbd_pkg::ST_MUL;
                        if (r_ph == rbd_pkg::PH_IDLE) begin
                            w_mb = 7'(100) - w_p;
                            n_k = K_THR_MUL;
                        end else if (r_ph == rbd_pkg::PH_DIP) begin
                            w_mb = r_endp;
                            n_k = K_END_MUL;
                        end else begin
                            w_mb = r_recp;
                            n_k = K_REC_MUL;
                        end
                    end
                    default: n_st = rbd_pkg::ST_JUDGE;
                endcase
            end
            rbd_pkg::ST_JUDGE: begin
                n_st = r_wend ? rbd_pkg::ST_SUM : rbd_pkg::ST_OUT;
                if (r_k == K_END_MUL && w_v100 > r_cmp && w_len_ok
                    && r_pre != '0 && r_dmin <= r_pre) begin
                    w_mstart = 1'b1;
                    w_ma = W'(r_pre - r_dmin);
                    w_mb = 7'd100;
                    n_st = rbd_pkg::ST_MUL;
                    n_k = K_DEPTH_MUL;
                end
            end
            rbd_pkg::ST_SUM: if (!(r_filled && r_ti != TCW'(CONF_TAPS))) begin
                n_st = rbd_pkg::ST_OUT;
            end
            rbd_pkg::ST_OUT: n_st = rbd_pkg::ST_IDLE;
            default: n_st = rbd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= rbd_pkg::ST_IDLE;
            r_k  <= K_DONE;
        end else begin
            r_st <= n_st;
            r_k  <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 10'd512; r_thr <= 7'd15; r_endp <= 7'd85; r_recp <= 7'd90;
            r_minl <= 5'd5; r_maxl <= 5'd20; r_maxp <= 7'd60;
            r_base <= '0; r_seeded <= 1'b0; r_ph <= rbd_pkg::PH_IDLE;
            r_dlen <= '0; r_dmin <= 10'h3FF; r_pre <= '0; r_tally <= '0;
            r_rate <= '0; r_conf <= '0; r_rpos <= '0; r_filled <= 1'b0;
            r_ovalid <= 1'b0; r_ti <= '0; r_sum <= '0;
            r_counted <= 1'b0; r_upd <= 1'b0;
            for (int i = 0; i < CONF_TAPS; i++) r_taps[i] <= '0;
        end else begin
            if (cfg.valid) begin
                case (rbd_pkg::t_cfg_idx'(cfg.index))
                    rbd_pkg::CFG_SEED:    r_seed <= cfg.data;
                    rbd_pkg::CFG_THRESH:  r_thr  <= cfg.data[6:0];
                    rbd_pkg::CFG_END:     r_endp <= cfg.data[6:0];
                    rbd_pkg::CFG_RECOVER: r_recp <= cfg.data[6:0];
                    rbd_pkg::CFG_MIN_LEN: r_minl <= cfg.data[4:0];
                    rbd_pkg::CFG_MAX_LEN: r_maxl <= cfg.data[4:0];
                    rbd_pkg::CFG_MAX_PCT: r_maxp <= cfg.data[6:0];
                    default: ;
                endcase
            end
            if (r_st == rbd_pkg::ST_OUT) r_ovalid <= 1'b1;
            else if (out.ready) r_ovalid <= 1'b0;
            if (w_acc) begin
                r_v <= in.sample;
                r_wend <= in.window_end;
                r_counted <= 1'b0;
                r_upd <= 1'b0;
                r_ti <= '0;
                r_sum <= '0;
                if (r_rpos < 7'(CONF_TAPS)) r_taps[r_rpos[TW-1:0]] <= in.sample;
                if (r_rpos + 7'd1 >= 7'(RING_LEN)) begin
                    r_rpos <= '0;
                    r_filled <= 1'b1;
                end else begin
                    r_rpos <= r_rpos + 7'd1;
                end
                r_seeded <= 1'b1;
            end
            if (r_st == rbd_pkg::ST_DIV && w_drsp.done && r_k == K_BASE_DIV)
                r_base <= w_drsp.quotient[SW-1:0];
            if (r_st == rbd_pkg::ST_DIV && w_drsp.done && r_k == K_THR_DIV)
                r_thres <= w_drsp.quotient[SW-1:0];
            if (r_st == rbd_pkg::ST_MUL && w_mdone)
                r_cmp <= w_mprod;
            if (r_st == rbd_pkg::ST_JUDGE) begin
                if (r_k == K_DEPTH_DIV) begin
                    if (w_pct_ok) begin
                        r_counted <= 1'b1;
                        if (r_tally != 8'd255) r_tally <= r_tally + 8'd1;
                    end
                end else begin
                    unique case (r_ph)
                        rbd_pkg::PH_IDLE: if (r_v < r_thres) begin
                            r_ph <= rbd_pkg::PH_DIP;
                            r_dlen <= 5'd1;
                            r_dmin <= r_v;
                            r_pre <= r_base;
                        end
                        rbd_pkg::PH_DIP: begin
                            if (w_v100 > r_cmp) r_ph <= rbd_pkg::PH_RECOVER;
                            else if (r_dlen > r_maxl) r_ph <= rbd_pkg::PH_IDLE;
                        end
                        default: if (w_v100 > r_cmp) r_ph <= rbd_pkg::PH_IDLE;
                    endcase
                end
            end
            if (r_st == rbd_pkg::ST_DIV && w_drsp.done && r_k == K_BASE_DIV
                && r_ph == rbd_pkg::PH_DIP) begin
                if (r_dlen != 5'd31) r_dlen <= r_dlen + 5'd1;
                if (r_v < r_dmin) r_dmin <= r_v;
            end
            if (r_st == rbd_pkg::ST_SUM) begin
                if (r_filled && r_ti != TCW'(CONF_TAPS)) begin
                    r_sum <= r_sum + SUMW'(w_dev);
                    r_ti <= r_ti + 1'b1;
                end else begin
                    if (r_filled) begin
                        r_rate <= w_rmul;
                        r_conf <= (r_sum < SUMW'(50)) ? 7'd90 :
                                  (r_sum < SUMW'(150)) ? 7'd70 : 7'd40;
                        r_upd <= 1'b1;
                    end
                    r_tally <= '0;
                end
            end
        end
    end

    // The depth path re-enters JUDGE with the phase already recovering.
    assign out.valid          = r_ovalid;
    assign out.amplitude      = r_v[SW-1:2];
    assign out.blink_counted  = r_counted;
    assign out.detector_state = r_ph;
    assign out.blink_rate     = r_rate;
    assign out.confidence     = r_conf;
    assign out.quality        = (r_conf > 7'd80) ? 2'd2 : (r_conf > 7'd50) ? 2'd1 : 2'd0;
    assign out.rate_updated   = r_upd;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != rbd_pkg::ST_IDLE) |-> !in.ready) else $error("accepted while busy");
    a_out_after_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_st == rbd_pkg::ST_OUT)) else $error("stray result");
    a_count_in_recover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_counted) |-> (r_ph == rbd_pkg::PH_RECOVER))
        else $error("blink outside recovery");
`endif
endmodule
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;

    typedef struct {
        logic [7:0] amplitude;
        logic       blink_counted;
        logic [1:0] detector_state;
        logic [7:0] blink_rate;
        logic [6:0] confidence;
        logic [1:0] quality;
        logic       rate_updated;
        bit         fixed;
        logic [7:0] fix_amplitude;
        logic       fix_updated;
        logic [7:0] fix_rate;
    } t_blink_word;

    typedef struct {
        int unsigned sample;
        bit          window_end;
        bit          fixed;
        int unsigned amplitude;
        bit          updated;
        int unsigned rate;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    rbd_in_if  in_if ();
    rbd_out_if out_if ();
    rbd_cfg_if cfg_if ();

    reflectance_blink_detector u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in      (in_if),
        .out     (out_if),
        .cfg     (cfg_if)
    );

    // register shadow
    int unsigned seed_lvl = 512, dip_pct = 15, end_pct = 85, rec_pct = 90;
    int unsigned len_lo = 5, len_hi = 20, depth_hi = 60;

    // detector shadow
    int unsigned base_lvl, dip_len, dip_low, pre_lvl, tally, rate_hold, conf_hold, ring_pos;
    bit          seeded, ring_full;
    rbd_pkg::t_phase det_phase;
    int unsigned early_taps[rbd_pkg::ConfTaps];

    t_blink_word expected_words[$];
    int          errors;
    int          src_idle, snk_idle;
    int          hold_cycles;
    bit          pressure_req;
    int unsigned level;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d (at %0t)", what, got, want, $realtime);
        errors++;
    endtask

    function automatic bit dip_is_blink();
        int unsigned depth;
        if (dip_len < len_lo || dip_len > len_hi) return 1'b0;
        if (pre_lvl == 0 || dip_low > pre_lvl) return 1'b0;
        depth = ((pre_lvl - dip_low) * 100) / pre_lvl;
        return depth >= dip_pct && depth <= depth_hi;
    endfunction

    function automatic t_blink_word predict_blink(input int unsigned v, input bit wend);
        t_blink_word r;
        int unsigned pct, thresh, sum;
        r = '{default: 0};
        if (ring_pos < rbd_pkg::ConfTaps) early_taps[ring_pos] = v;
        ring_pos++;
        if (ring_pos >= rbd_pkg::RingLen) begin
            ring_pos  = 0;
            ring_full = 1'b1;
        end
        if (!seeded) begin
            base_lvl = seed_lvl;
            seeded   = 1'b1;
        end
        base_lvl = (19 * base_lvl + v) / 20;
        pct    = dip_pct > 100 ? 100 : dip_pct;
        thresh = base_lvl * (100 - pct) / 100;
        case (det_phase)
            rbd_pkg::PH_IDLE: begin
                if (v < thresh) begin
                    det_phase = rbd_pkg::PH_DIP;
                    dip_len   = 1;
                    dip_low   = v;
                    pre_lvl   = base_lvl;
                end
            end
            rbd_pkg::PH_DIP: begin
                if (dip_len < 31) dip_len++;
                if (v < dip_low) dip_low = v;
                if (v * 100 > base_lvl * end_pct) begin
                    if (dip_is_blink()) begin
                        r.blink_counted = 1'b1;
                        if (tally < 255) tally++;
                    end
                    det_phase = rbd_pkg::PH_RECOVER;
                end else if (dip_len > len_hi) begin
                    det_phase = rbd_pkg::PH_IDLE;
                end
            end
            default: begin
                if (v * 100 > base_lvl * rec_pct) det_phase = rbd_pkg::PH_IDLE;
            end
        endcase
        if (wend) begin
            if (ring_full) begin
                rate_hold = tally * rbd_pkg::RateScale > 255 ? 255
                                                             : tally * rbd_pkg::RateScale;
                sum = 0;
                foreach (early_taps[i])
                    sum += early_taps[i] > base_lvl ? early_taps[i] - base_lvl
                                                    : base_lvl - early_taps[i];
                conf_hold = sum < 50 ? 90 : (sum < 150 ? 70 : 40);
                r.rate_updated = 1'b1;
            end
            tally = 0;
        end
        r.amplitude      = v >> 2;
        r.detector_state = det_phase;
        r.blink_rate     = rate_hold;
        r.confidence     = conf_hold;
        r.quality        = conf_hold > 80 ? 2 : (conf_hold > 50 ? 1 : 0);
        return r;
    endfunction

    task automatic send_word(input int unsigned v, input bit wend, input t_stim_row row);
        t_blink_word r;
        while ($urandom_range(0, 99) < src_idle) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.sample     <= v[9:0];
        in_if.window_end <= wend;
        do @(posedge i_clk); while (!in_if.ready);
        r = predict_blink(v, wend);
        r.fixed         = row.fixed;
        r.fix_amplitude = row.amplitude[7:0];
        r.fix_updated   = row.updated;
        r.fix_rate      = row.rate[7:0];
        expected_words.push_back(r);
    endtask

    task automatic send_sample(input int unsigned v);
        t_stim_row none;
        none = '{default: 0};
        send_word(v, $urandom_range(0, 29) == 0, none);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic cfg_write(input rbd_pkg::t_cfg_idx idx, input int unsigned val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val[9:0];
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            rbd_pkg::CFG_SEED:    seed_lvl = val & 10'h3FF;
            rbd_pkg::CFG_THRESH:  dip_pct  = val & 7'h7F;
            rbd_pkg::CFG_END:     end_pct  = val & 7'h7F;
            rbd_pkg::CFG_RECOVER: rec_pct  = val & 7'h7F;
            rbd_pkg::CFG_MIN_LEN: len_lo   = val & 5'h1F;
            rbd_pkg::CFG_MAX_LEN: len_hi   = val & 5'h1F;
            default:              depth_hi = val & 7'h7F;
        endcase
    endtask

    task automatic set_regs(input int unsigned s, input int unsigned t, input int unsigned e,
                            input int unsigned rc, input int unsigned lo,
                            input int unsigned hi, input int unsigned dp);
        cfg_write(rbd_pkg::CFG_SEED, s);
        cfg_write(rbd_pkg::CFG_THRESH, t);
        cfg_write(rbd_pkg::CFG_END, e);
        cfg_write(rbd_pkg::CFG_RECOVER, rc);
        cfg_write(rbd_pkg::CFG_MIN_LEN, lo);
        cfg_write(rbd_pkg::CFG_MAX_LEN, hi);
        cfg_write(rbd_pkg::CFG_MAX_PCT, dp);
        cfg_if.valid <= 1'b0;
    endtask

    // steady level, then a dip of random length and depth, then recovery; else noise or one full-scale or zero sample
    task automatic random_burst(inout int sent);
        int unsigned kind, hold, dlen, depth, v;
        kind = $urandom_range(0, 9);
        if ($urandom_range(0, 4) == 0) level = $urandom_range(60, 1023);
        if (kind < 7) begin
            hold  = $urandom_range(3, 30);
            dlen  = $urandom_range(1, 34);
            depth = $urandom_range(5, 98);
            repeat (hold) begin
                v = level + $urandom_range(0, 8);
                send_sample(v > 1023 ? 1023 : v - 4);
                sent++;
            end
            repeat (dlen) begin
                v = level * (100 - depth) / 100 + $urandom_range(0, 6);
                send_sample(v > 1023 ? 1023 : v);
                sent++;
            end
            repeat ($urandom_range(1, 6)) begin
                send_sample(level);
                sent++;
            end
        end else if (kind < 9) begin
            repeat ($urandom_range(1, 8)) begin
                send_sample($urandom_range(0, 1023));
                sent++;
            end
        end else begin
            send_sample($urandom_range(0, 1) ? 1023 : 0);
            sent++;
        end
    endtask

    task automatic random_run(input int count);
        int sent;
        sent = 0;
        while (sent < count) random_burst(sent);
    endtask

    t_stim_row directed_rows[] = '{
        '{512, 1, 1, 128, 0, 0},
        '{512, 0, 1, 128, 0, 0},
        '{512, 0, 0, 0, 0, 0},
        '{300, 0, 0, 0, 0, 0},
        '{300, 0, 0, 0, 0, 0},
        '{300, 0, 0, 0, 0, 0},
        '{300, 0, 0, 0, 0, 0},
        '{300, 0, 0, 0, 0, 0},
        '{300, 0, 0, 0, 0, 0},
        '{512, 0, 0, 0, 0, 0},
        '{512, 0, 0, 0, 0, 0},
        '{0, 0, 1, 0, 0, 0},
        '{1023, 0, 1, 255, 0, 0},
        '{1023, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0},
        '{700, 0, 0, 0, 0, 0},
        '{1023, 1, 1, 255, 0, 0}
    };

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_cycles = 0;
        end else begin
            if (pressure_req) begin
                hold_cycles  = 500;
                pressure_req = 1'b0;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= $urandom_range(0, 99) >= snk_idle;
            end
        end
    end

    always @(posedge i_clk) begin : check_words
        t_blink_word e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_words.size() == 0) begin
                report("unexpected word", out_if.amplitude, -1);
            end else begin
                e = expected_words.pop_front();
                if (out_if.amplitude !== e.amplitude)
                    report("amplitude", out_if.amplitude, e.amplitude);
                if (out_if.blink_counted !== e.blink_counted)
                    report("blink_counted", out_if.blink_counted, e.blink_counted);
                if (out_if.detector_state !== e.detector_state)
                    report("detector_state", out_if.detector_state, e.detector_state);
                if (out_if.blink_rate !== e.blink_rate)
                    report("blink_rate", out_if.blink_rate, e.blink_rate);
                if (out_if.confidence !== e.confidence)
                    report("confidence", out_if.confidence, e.confidence);
                if (out_if.quality !== e.quality)
                    report("quality", out_if.quality, e.quality);
                if (out_if.rate_updated !== e.rate_updated)
                    report("rate_updated", out_if.rate_updated, e.rate_updated);
                if (e.fixed && (out_if.amplitude !== e.fix_amplitude
                        || out_if.rate_updated !== e.fix_updated
                        || out_if.blink_rate !== e.fix_rate))
                    report("directed word", out_if.amplitude, e.fix_amplitude);
            end
        end
    end

    initial begin
        errors       = 0;
        src_idle     = 26;
        snk_idle     = 73;
        pressure_req = 1'b0;
        level        = 512;
        base_lvl = 0; dip_len = 0; dip_low = 1023; pre_lvl = 0; tally = 0;
        rate_hold = 0; conf_hold = 0; ring_pos = 0; seeded = 0; ring_full = 0;
        det_phase = rbd_pkg::PH_IDLE;
        foreach (early_taps[i]) early_taps[i] = 0;
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.sample     <= '0;
        in_if.window_end <= 1'b0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= rbd_pkg::CFG_SEED;
        cfg_if.data      <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].sample, directed_rows[i].window_end, directed_rows[i]);
        random_run(280);
        drain();

        set_regs(0, 0, 0, 0, 0, 31, 0);
        random_run(300);
        drain();

        src_idle = 73;
        snk_idle = 26;
        set_regs(1023, 99, 100, 100, 30, 30, 100);
        pressure_req = 1'b1;
        random_run(300);
        drain();

        // threshold beyond 100 percent: no dip can start
        set_regs($urandom_range(0, 1023), 127, 127, 127, 1, 1, 127);
        random_run(300);
        drain();

        src_idle = 0;
        snk_idle = 0;
        set_regs(700, 20, 85, 90, 25, 3, 60);
        random_run(300);
        drain();

        set_regs($urandom_range(0, 1023), $urandom_range(5, 30), $urandom_range(60, 95),
                 $urandom_range(70, 100), $urandom_range(1, 6), $urandom_range(10, 30),
                 $urandom_range(40, 100));
        random_run(300);
        drain();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
